### sv/nps_pkg.sv
// nps_pkg: shared types, widths and helper functions for the nearest palette search
// used by the channel interface instantiation and the top level; no dependencies
package nps_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int SIZE_W            = 9;
    localparam int IDX_W             = 8;
    localparam int CH_W              = 8;
    localparam int SQ_W              = 2 * CH_W;
    // r^2 + g^2 + b^2 + 3 a^2 peaks at 390150
    localparam int DIST_W            = 19;

    typedef enum logic
    {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef logic [CH_W-1:0]   chan_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [DIST_W-1:0] dist_t;

    typedef struct packed
    {
        kind_t kind;
        idx_t  entry_index;
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
    } req_t;

    typedef struct packed
    {
        idx_t best_index;
        logic found;
    } rsp_t;

    typedef struct packed
    {
        chan_t alpha;
        chan_t blue;
        chan_t green;
        chan_t red;
    } entry_t;

    function automatic sq_t sq_diff(input chan_t a, input chan_t b);
        chan_t d;
        d = (a >= b) ? (a - b) : (b - a);
        return sq_t'(d) * sq_t'(d);
    endfunction

    // d_r + d_g + d_b + 3 * d_a, done with a shift and adds
    function automatic dist_t weigh(input sq_t r, input sq_t g, input sq_t b, input sq_t a);
        return dist_t'(r) + dist_t'(g) + dist_t'(b) + (dist_t'(a) << 1) + dist_t'(a);
    endfunction

endpackage

### sv/nps_chan_if.sv
// nps_chan_if: valid/ready channel carrying one payload item per handshake
// payload type is set per instance; no package dependency
interface nps_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/nearest_palette_rgba_search_top.sv
// nearest palette search: a palette write is taken in idle; a query scans its n active entries
// (n = min(palette_size, PALETTE_DEPTH)) through the read, square and compare steps, then loads
// its result into the output register, after which the block is ready for the next item
// throughput: one item at a time, the scan reads one palette entry per cycle from the
// single read port; a result held at the output keeps the next query in its done state
// reset (rst_n, async, active low) clears control state and palette_size to zero
module nearest_palette_rgba_search_top #(
    parameter int PALETTE_DEPTH = nps_pkg::PALETTE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    nps_chan_if.sink   req,
    nps_chan_if.source rsp,
    nps_chan_if.sink   cfg
);

    // address width of the palette memory, at least one bit
    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam nps_pkg::size_t DEPTH_SZ = nps_pkg::size_t'(PALETTE_DEPTH);

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // ---------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------
    state_t            state_reg, state_next;
    nps_pkg::size_t    size_reg;          // configured palette size
    nps_pkg::size_t    count_reg;         // saturated entry count for the current query
    nps_pkg::size_t    issue_cnt_reg;     // next entry address to read

    // query pixel held during the scan
    nps_pkg::chan_t    q_red_reg, q_green_reg, q_blue_reg, q_alpha_reg;

    // read stage: memory data plus its entry index
    logic              rd_vld_reg;
    nps_pkg::idx_t     rd_idx_reg;
    nps_pkg::entry_t   mem_q_reg;

    // square stage
    logic              sq_vld_reg;
    nps_pkg::idx_t     sq_idx_reg;
    nps_pkg::sq_t      sq_r_reg, sq_g_reg, sq_b_reg, sq_a_reg;

    // running best
    logic              found_reg;
    nps_pkg::idx_t     best_idx_reg;
    nps_pkg::dist_t    best_dist_reg;

    // output register
    logic              out_vld_reg;
    nps_pkg::rsp_t     out_reg;

    // palette memory, one 32-bit word per entry, synchronous read
    nps_pkg::entry_t   palette_mem [PALETTE_DEPTH];

    // ---------------------------------------------------------------------
    // control decode
    // ---------------------------------------------------------------------
    nps_pkg::req_t     req_item;
    nps_pkg::size_t    count_sat;
    nps_pkg::dist_t    cand_dist;
    logic              req_fire;
    logic              wr_en;
    logic              rd_en;
    logic              scan_end;
    logic              out_load;
    logic              take_new;

    assign req_item  = req.data;
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    // writes to an entry beyond the memory are dropped
    assign wr_en = req_fire && (req_item.kind == nps_pkg::KIND_WRITE)
                   && ({1'b0, req_item.entry_index} < DEPTH_SZ);

    // sizes above the memory depth search the whole memory
    assign count_sat = (size_reg > DEPTH_SZ) ? DEPTH_SZ : size_reg;

    // one read per cycle while entries remain
    assign rd_en = (state_reg == ST_SCAN) && (issue_cnt_reg < count_reg);

    // all reads issued and the pipe has drained
    assign scan_end = (state_reg == ST_SCAN) && !rd_en && !rd_vld_reg && !sq_vld_reg;

    // result moves out once the output register is free or being emptied
    assign out_load = (state_reg == ST_DONE) && (!out_vld_reg || rsp.ready);

    assign cfg.ready = 1'b1;

    assign cand_dist = nps_pkg::weigh(sq_r_reg, sq_g_reg, sq_b_reg, sq_a_reg);
    // strict less keeps the lowest index on a tie
    assign take_new  = sq_vld_reg && (!found_reg || (cand_dist < best_dist_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req_item.kind == nps_pkg::KIND_QUERY))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= '0;
            count_reg     <= '0;
            issue_cnt_reg <= '0;
            rd_vld_reg    <= 1'b0;
            sq_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            sq_vld_reg <= rd_vld_reg;

            if (cfg.valid && cfg.ready)
            begin
                size_reg <= cfg.data;
            end

            if (req_fire && (req_item.kind == nps_pkg::KIND_QUERY))
            begin
                count_reg     <= count_sat;
                issue_cnt_reg <= '0;
                found_reg     <= 1'b0;
            end
            else
            begin
                if (rd_en)
                begin
                    issue_cnt_reg <= issue_cnt_reg + nps_pkg::size_t'(1);
                end
                if (take_new)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // datapath registers, no reset
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            q_red_reg   <= req_item.red;
            q_green_reg <= req_item.green;
            q_blue_reg  <= req_item.blue;
            q_alpha_reg <= req_item.alpha;
        end

        // read stage tag
        rd_idx_reg <= issue_cnt_reg[nps_pkg::IDX_W-1:0];

        // squared channel differences
        sq_idx_reg <= rd_idx_reg;
        sq_r_reg   <= nps_pkg::sq_diff(mem_q_reg.red,   q_red_reg);
        sq_g_reg   <= nps_pkg::sq_diff(mem_q_reg.green, q_green_reg);
        sq_b_reg   <= nps_pkg::sq_diff(mem_q_reg.blue,  q_blue_reg);
        sq_a_reg   <= nps_pkg::sq_diff(mem_q_reg.alpha, q_alpha_reg);

        if (take_new)
        begin
            best_dist_reg <= cand_dist;
            best_idx_reg  <= sq_idx_reg;
        end

        if (out_load)
        begin
            // an empty palette reports index zero, not found
            out_reg.found      <= found_reg;
            out_reg.best_index <= found_reg ? best_idx_reg : '0;
        end
    end

    // ---------------------------------------------------------------------
    // palette memory: one write port, one registered read port
    // writes only happen in idle, so a scan never overlaps a write
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            palette_mem[req_item.entry_index[AW-1:0]] <= {req_item.alpha, req_item.blue,
                                                          req_item.green, req_item.red};
        end
        if (rd_en)
        begin
            mem_q_reg <= palette_mem[issue_cnt_reg[AW-1:0]];
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_reg;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    // no new item is taken while entries are still in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (!rd_vld_reg && !sq_vld_reg))
        else $error("input ready while scan pipe busy");

    // reads never run past the entry count of the query
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg <= count_reg))
        else $error("scan address past entry count");

    // a loaded result is presented at the output with the block back in idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_vld_reg && (state_reg == ST_IDLE))
        else $error("result not presented after scan end");

    // a query over entries always finds one
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_end && (count_reg != '0) |-> found_reg)
        else $error("non-empty scan ended without a hit");

    // not-found results carry index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.data.found) |-> (rsp.data.best_index == '0))
        else $error("empty result with nonzero index");

endmodule

### sim/palette_search_checker.sv
// palette_search_checker: watches the request, result and size channels of the palette search
// keeps its own palette copy, predicts each query result and compares in order; needs nps_pkg
module palette_search_checker
    import nps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  req_t        req_data,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  rsp_t        rsp_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  size_t       cfg_data,
    output int unsigned outstanding,
    output int unsigned fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH        = PALETTE_DEPTH_DEF;
    localparam int unsigned ALPHA_WEIGHT = 3;

    entry_t      palette_copy [DEPTH];
    size_t       active_size;
    rsp_t        nearest_q [$];
    int unsigned owed_count = 0;
    int unsigned fail_tally = 0;

    assign outstanding = owed_count;
    assign fail_count  = fail_tally;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_tally++;
    endtask

    function automatic int unsigned color_distance(input entry_t a, input entry_t b);
        int dr;
        int dg;
        int db;
        int da;
        dr = int'(a.red) - int'(b.red);
        dg = int'(a.green) - int'(b.green);
        db = int'(a.blue) - int'(b.blue);
        da = int'(a.alpha) - int'(b.alpha);
        return dr * dr + dg * dg + db * db + ALPHA_WEIGHT * da * da;
    endfunction

    // lowest index wins on equal distance
    function automatic rsp_t nearest_entry(input entry_t px);
        int unsigned span;
        int unsigned k;
        int unsigned cand_dist;
        int unsigned best_dist;
        rsp_t        pick;
        span      = (active_size > DEPTH) ? DEPTH : active_size;
        pick      = '0;
        best_dist = 0;
        for (k = 0; k < span; k++)
        begin
            cand_dist = color_distance(palette_copy[k], px);
            if (!pick.found || cand_dist < best_dist)
            begin
                best_dist       = cand_dist;
                pick.best_index = idx_t'(k);
                pick.found      = 1'b1;
            end
        end
        return pick;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        entry_t px;
        rsp_t   want;
        if (!rst_n)
        begin
            active_size = '0;
            nearest_q.delete();
            owed_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                active_size = cfg_data;
            if (req_valid && req_ready)
            begin
                px = '{alpha: req_data.alpha, blue: req_data.blue,
                       green: req_data.green, red: req_data.red};
                if (req_data.kind == KIND_WRITE)
                    palette_copy[req_data.entry_index] = px;
                else
                    nearest_q.push_back(nearest_entry(px));
            end
            if (rsp_valid && rsp_ready)
            begin
                if (nearest_q.size() == 0)
                    report_mismatch($sformatf("result with none pending: index %0d found %0b",
                                              rsp_data.best_index, rsp_data.found));
                else
                begin
                    want = nearest_q.pop_front();
                    if (rsp_data.best_index !== want.best_index)
                        report_mismatch($sformatf("best_index got %0d want %0d",
                                                  rsp_data.best_index, want.best_index));
                    if (rsp_data.found !== want.found)
                        report_mismatch($sformatf("found got %0b want %0b",
                                                  rsp_data.found, want.found));
                end
            end
            owed_count <= nearest_q.size();
        end
    end

endmodule

### sim/tb_top.sv
// tb_top: stimulus and verdict for nearest_palette_rgba_search_top
// depends on nps_pkg, nps_chan_if, the block and palette_search_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import nps_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 2;
    localparam int MAX_GAP       = 8;
    // the settle time outlasts a full 256 entry scan
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int TARGET_ITEMS  = 1900;
    localparam int DEPTH         = PALETTE_DEPTH_DEF;

    logic clk;
    logic rst_n;

    nps_chan_if #(.payload_t(req_t))  req_if ();
    nps_chan_if #(.payload_t(rsp_t))  rsp_if ();
    nps_chan_if #(.payload_t(size_t)) cfg_if ();

    int unsigned results_owed;
    int unsigned fail_count;
    int unsigned items_sent   = 0;
    int unsigned quiet_cycles = 0;
    bit          burst_mode   = 1'b0;
    bit          hold_rsp     = 1'b0;

    // what the stimulus believes is in the palette, used to aim queries at entries
    entry_t shadow [DEPTH];

    nearest_palette_rgba_search_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    palette_search_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_if.valid),
        .req_ready   (req_if.ready),
        .req_data    (req_if.data),
        .rsp_valid   (rsp_if.valid),
        .rsp_ready   (rsp_if.ready),
        .rsp_data    (rsp_if.data),
        .cfg_valid   (cfg_if.valid),
        .cfg_ready   (cfg_if.ready),
        .cfg_data    (cfg_if.data),
        .outstanding (results_owed),
        .fail_count  (fail_count)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    // watchdog: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random ready gaps per item, one long hold when asked
    initial
    begin : rsp_sink
        int unsigned gap;
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                // block fills up behind the held result and stalls its input
                rsp_if.ready <= 1'b0;
                hold_rsp = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
                if (gap != 0)
                begin
                    rsp_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
        end
    end

    function automatic entry_t rgba(input chan_t r, input chan_t g, input chan_t b,
                                    input chan_t a);
        return '{alpha: a, blue: b, green: g, red: r};
    endfunction

    // channel values lean toward the two extremes
    function automatic chan_t extreme_or_any();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic chan_t nudge(input chan_t c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return chan_t'(v);
    endfunction

    // copies of existing entries make equal distances likely
    function automatic entry_t random_color();
        if ($urandom_range(0, 3) == 0)
            return shadow[$urandom_range(0, DEPTH - 1)];
        return rgba(extreme_or_any(), extreme_or_any(), extreme_or_any(), extreme_or_any());
    endfunction

    // queries: random, near an active entry, exactly on one, or at the corners
    function automatic entry_t pick_query(input int unsigned span);
        int unsigned sel;
        entry_t      aim;
        sel = $urandom_range(0, 9);
        aim = (span == 0) ? '0 : shadow[$urandom_range(0, span - 1)];
        if (sel < 4 || span == 0)
            return rgba(extreme_or_any(), extreme_or_any(), extreme_or_any(), extreme_or_any());
        if (sel < 7)
            return rgba(nudge(aim.red), nudge(aim.green), nudge(aim.blue), nudge(aim.alpha));
        if (sel < 9)
            return aim;
        return rgba($urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                    $urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00);
    endfunction

    // valid stays high across back to back items, lowered only for a gap
    task automatic send_item(input req_t item);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        do @(posedge clk); while (!req_if.ready);
        items_sent++;
    endtask

    task automatic write_entry(input idx_t at, input entry_t color);
        req_t item;
        shadow[at]       = color;
        item.kind        = KIND_WRITE;
        item.entry_index = at;
        item.red         = color.red;
        item.green       = color.green;
        item.blue        = color.blue;
        item.alpha       = color.alpha;
        send_item(item);
    endtask

    task automatic query_pixel(input entry_t px);
        req_t item;
        item.kind        = KIND_QUERY;
        item.entry_index = idx_t'($urandom_range(0, 255));
        item.red         = px.red;
        item.green       = px.green;
        item.blue        = px.blue;
        item.alpha       = px.alpha;
        send_item(item);
    endtask

    // sender pauses until every query has its result
    task automatic drain();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
    endtask

    // size changes only with the block idle; pending queries are drained first
    task automatic set_palette_size(input size_t entries);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= entries;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned count;
        int unsigned span;
        int unsigned n;
        int unsigned i;
        size_t       entries;
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        for (i = 0; i < DEPTH; i++)
            shadow[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty palette right after reset: found must be clear
        query_pixel(rgba(8'h12, 8'h34, 8'h56, 8'h78));

        // four entries: black, white, magenta with no alpha, and a second white
        write_entry(8'd0, rgba(8'h00, 8'h00, 8'h00, 8'h00));
        write_entry(8'd1, rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        write_entry(8'd2, rgba(8'hFF, 8'h00, 8'hFF, 8'h00));
        write_entry(8'd3, rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));

        // single entry palette: always index 0
        set_palette_size(size_t'(1));
        query_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));

        set_palette_size(size_t'(4));
        query_pixel(rgba(8'h00, 8'h00, 8'h00, 8'h00));
        // white ties between entries 1 and 3, lower index wins
        query_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        query_pixel(rgba(8'hFF, 8'h00, 8'hFF, 8'h00));
        // with the alpha weight of three, black and white tie here and the lower index wins
        query_pixel(rgba(8'h00, 8'h00, 8'h00, 8'hFF));
        query_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'h00));

        // fill the whole palette so any size may be searched from here on
        for (i = 0; i < DEPTH; i++)
            write_entry(idx_t'(i), random_color());

        phase = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            // fixed plan first (extremes, saturation above depth), then mostly small sizes
            case (phase)
                0: entries = size_t'(256);
                1: entries = size_t'(9);
                2: entries = size_t'(1);
                3: entries = size_t'(511);
                4: entries = size_t'(2);
                5: entries = size_t'(0);
                6: entries = size_t'(257);
                7: entries = size_t'(33);
                8: entries = size_t'(3);
                9: entries = size_t'(130);
                default:
                    if ($urandom_range(0, 5) == 0)
                        entries = size_t'($urandom_range(128, 511));
                    else
                        entries = size_t'($urandom_range(0, 40));
            endcase
            set_palette_size(entries);
            span  = (entries > DEPTH) ? DEPTH : entries;
            count = (span >= 128) ? 25 : ((span == 0) ? 30 : 150);
            burst_mode = ($urandom_range(0, 3) == 0);
            if (phase == 1)
                hold_rsp = 1'b1;
            for (n = 0; n < count; n++)
            begin
                if (phase % 3 == 2 && n == count / 2)
                    drain();
                if ($urandom_range(0, 3) == 0)
                    write_entry(idx_t'($urandom_range(0, 255)), random_color());
                else
                    query_pixel(pick_query(span));
            end
            phase++;
        end

        // let everything settle, then watch for stray results
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
sv/nps_pkg.sv
sv/nps_chan_if.sv
sv/nearest_palette_rgba_search_top.sv
sim/palette_search_checker.sv
sim/tb_top.sv
